[hdl/pctd_pkg.sv]
// Package with the shared types and constants of the prefix code table build and decode block.
`default_nettype none
package pctd_pkg;

  localparam int NODE_COUNT_DEF = 1024;
  localparam logic [7:0] KEY_RESET = 8'hC7 ^ 8'hE7 ^ 8'hB7;

  localparam logic [2:0] ST_RUNNING   = 3'd0;
  localparam logic [2:0] ST_DONE      = 3'd1;
  localparam logic [2:0] ST_TABLE_ERR = 3'd2;
  localparam logic [2:0] ST_NO_CHILD  = 3'd3;
  localparam logic [2:0] ST_TRUNCATED = 3'd4;

  localparam logic [1:0] REG_XOR_KEY = 2'd0;

  typedef struct packed {
    logic       command;
    logic [7:0] stream_byte;
    logic       stream_end;
  } in_t;

  typedef struct packed {
    logic [7:0] symbol;
    logic       symbol_valid;
    logic       last_symbol;
    logic [2:0] status;
  } out_t;

  typedef struct packed {
    logic       restart;
    logic [7:0] data;
    logic       stream_end;
  } item_t;

endpackage
`default_nettype wire

[hdl/prefix_code_table_build_and_decode.sv]
// Top level of the prefix code table build and decode block.
// Input channel in_valid/in_ready/in_data carries one stream byte or a restart per
// transaction; each byte is XORed with the key register before parsing.
// Result channel out_valid/out_ready/out_data carries one transaction per decoded
// symbol, or a single transaction without a symbol when the byte yields none; the
// last result of each input carries last_symbol and the status.
// The key register sits at byte address 0 of the APB port and resets to 0x97.
// Header, symbol, length and restart bytes go from the idle state straight to the
// finish state in the back end, which registers their result. A code or payload byte
// takes a read, a check and an allocate or descend step per bit for up to eight bits,
// bounded by the single write port and the registered read port of the node RAM.
// A two-entry queue lets the input side keep accepting while the back end works.
// After reset the root node is written before the first transaction is processed;
// the node RAM is otherwise left uninitialized.
// When the receiver stalls, the back end holds its next symbol and stops walking.
`default_nettype none
module prefix_code_table_build_and_decode #(
  parameter int NODE_COUNT = pctd_pkg::NODE_COUNT_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire pctd_pkg::in_t  in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output pctd_pkg::out_t      out_data,
  input  wire logic           psel,
  input  wire logic           penable,
  input  wire logic           pwrite,
  input  wire logic [1:0]     paddr,
  input  wire logic [31:0]    pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import pctd_pkg::*;

  logic  q_valid;
  logic  q_pop;
  item_t q_data;

  pctd_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data (in_data),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .q_data  (q_data)
  );

  pctd_back #(
    .NODE_COUNT(NODE_COUNT)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_data   (q_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule
`default_nettype wire

[hdl/pctd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module pctd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[hdl/pctd_front.sv]
// Front end: key register, input acceptance, key XOR and a two-entry transaction queue.
`default_nettype none
module pctd_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire pctd_pkg::in_t in_data,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [1:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output logic               q_valid,
  input  wire logic          q_pop,
  output pctd_pkg::item_t    q_data
);
  import pctd_pkg::*;

  logic [7:0] key_r;
  item_t      slot_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push;
  item_t      item;

  assign pready = 1'b1;
  assign prdata = (paddr == REG_XOR_KEY) ? {24'd0, key_r} : 32'd0;

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_data   = slot_r[rp_r];

  always_comb begin
    item.restart    = in_data.command;
    item.data       = in_data.stream_byte ^ key_r;
    item.stream_end = in_data.stream_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= KEY_RESET;
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (psel && penable && pwrite && paddr == REG_XOR_KEY) begin
        key_r <= pwdata[7:0];
      end
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (q_pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= item;
    end
  end

endmodule
`default_nettype wire

[hdl/pctd_back.sv]
// Back end: header parsing, node table build, payload walk and result register.
`default_nettype none
module pctd_back #(
  parameter int NODE_COUNT = pctd_pkg::NODE_COUNT_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            q_valid,
  output logic                 q_pop,
  input  wire pctd_pkg::item_t q_data,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output pctd_pkg::out_t       out_data
);
  import pctd_pkg::*;

  localparam int AW = $clog2(NODE_COUNT);
  localparam int EW = 1 + 2 * AW + 8;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_RD    = 7'b0000010,
    S_CHK   = 7'b0000100,
    S_ALLOC = 7'b0001000,
    S_CHK2  = 7'b0010000,
    S_PCHK  = 7'b0100000,
    S_FIN   = 7'b1000000
  } state_t;

  typedef enum logic [6:0] {
    PH_COUNT   = 7'b0000001,
    PH_OUTLEN  = 7'b0000010,
    PH_SYM     = 7'b0000100,
    PH_LEN     = 7'b0001000,
    PH_CODE    = 7'b0010000,
    PH_PAYLOAD = 7'b0100000,
    PH_DONE    = 7'b1000000
  } phase_t;

  state_t        state_r, state_nxt;
  phase_t        phase_r, phase_nxt;
  logic [1:0]    hdr_r, hdr_nxt;
  logic [31:0]   codes_r, codes_nxt;
  logic [31:0]   ol_r, ol_nxt;
  logic [7:0]    pend_r, pend_nxt;
  logic [7:0]    len_r, len_nxt;
  logic [7:0]    idx_r, idx_nxt;
  logic [AW-1:0] cur_r, cur_nxt;
  logic [AW-1:0] child_r, child_nxt;
  logic [AW:0]   nfree_r, nfree_nxt;
  logic          err_r, err_nxt;
  logic [2:0]    ecode_r, ecode_nxt;
  logic [7:0]    b_r, b_nxt;
  logic          end_r, end_nxt;
  logic [3:0]    k_r, k_nxt;
  logic [7:0]    hold_r, hold_nxt;
  logic          hold_v_r, hold_v_nxt;
  logic          init_r, init_nxt;
  logic          out_valid_r;
  out_t          out_data_r;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_wa, ram_ra;
  logic [EW-1:0] ram_wd, rd_data;
  logic          push;
  out_t          push_data;
  logic          out_free;
  logic          bit_v, rd_leaf, final_bit, trunc;
  logic [AW-1:0] rd_c1, rd_c0, rd_child;
  logic [31:0]   ol_new;
  logic [2:0]    status;

  function automatic phase_t next_phase(input logic [31:0] codes, input logic [31:0] ol);
    phase_t p;
    if (codes != 32'd0) begin
      p = PH_SYM;
    end else if (ol != 32'd0) begin
      p = PH_PAYLOAD;
    end else begin
      p = PH_DONE;
    end
    return p;
  endfunction

  pctd_ram #(
    .WIDTH(EW),
    .DEPTH(NODE_COUNT)
  ) u_nodes (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_wa),
    .wdata(ram_wd),
    .re   (ram_re),
    .raddr(ram_ra),
    .rdata(rd_data)
  );

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign bit_v     = b_r[k_r[2:0]];
  assign rd_leaf   = rd_data[EW-1];
  assign rd_c1     = rd_data[8+AW +: AW];
  assign rd_c0     = rd_data[8 +: AW];
  assign rd_child  = bit_v ? rd_c1 : rd_c0;
  assign final_bit = ({1'b0, idx_r} + 9'd1) == {1'b0, len_r};
  assign ol_new    = {ol_r[23:0], q_data.data};
  assign trunc     = end_r && !err_r && (phase_r != PH_DONE);

  always_comb begin
    if (err_r) begin
      status = ecode_r;
    end else if (trunc) begin
      status = ST_TRUNCATED;
    end else if (phase_r == PH_DONE) begin
      status = ST_DONE;
    end else begin
      status = ST_RUNNING;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    phase_nxt  = phase_r;
    hdr_nxt    = hdr_r;
    codes_nxt  = codes_r;
    ol_nxt     = ol_r;
    pend_nxt   = pend_r;
    len_nxt    = len_r;
    idx_nxt    = idx_r;
    cur_nxt    = cur_r;
    child_nxt  = child_r;
    nfree_nxt  = nfree_r;
    err_nxt    = err_r;
    ecode_nxt  = ecode_r;
    b_nxt      = b_r;
    end_nxt    = end_r;
    k_nxt      = k_r;
    hold_nxt   = hold_r;
    hold_v_nxt = hold_v_r;
    init_nxt   = init_r;
    ram_we     = 1'b0;
    ram_wa     = '0;
    ram_wd     = '0;
    ram_re     = 1'b0;
    ram_ra     = cur_r;
    q_pop      = 1'b0;
    push       = 1'b0;
    push_data  = '0;

    unique case (state_r)
      S_IDLE: begin
        if (init_r) begin
          ram_we   = 1'b1;
          init_nxt = 1'b0;
        end else if (q_valid) begin
          q_pop   = 1'b1;
          b_nxt   = q_data.data;
          end_nxt = q_data.stream_end && !q_data.restart;
          k_nxt   = 4'd0;
          state_nxt = S_FIN;
          if (q_data.restart) begin
            ram_we    = 1'b1;
            phase_nxt = PH_COUNT;
            hdr_nxt   = 2'd0;
            codes_nxt = 32'd0;
            ol_nxt    = 32'd0;
            pend_nxt  = 8'd0;
            len_nxt   = 8'd0;
            idx_nxt   = 8'd0;
            cur_nxt   = '0;
            nfree_nxt = (AW+1)'(1);
            err_nxt   = 1'b0;
            ecode_nxt = ST_RUNNING;
          end else if (!err_r) begin
            unique case (phase_r) inside
              PH_COUNT: begin
                codes_nxt = {codes_r[23:0], q_data.data};
                hdr_nxt   = hdr_r + 2'd1;
                if (hdr_r == 2'd3) begin
                  phase_nxt = PH_OUTLEN;
                end
              end
              PH_OUTLEN: begin
                ol_nxt  = ol_new;
                hdr_nxt = hdr_r + 2'd1;
                if (hdr_r == 2'd3) begin
                  cur_nxt   = '0;
                  phase_nxt = next_phase(codes_r, ol_new);
                end
              end
              PH_SYM: begin
                pend_nxt  = q_data.data;
                phase_nxt = PH_LEN;
              end
              PH_LEN: begin
                len_nxt = q_data.data;
                idx_nxt = 8'd0;
                cur_nxt = '0;
                if (q_data.data == 8'd0) begin
                  codes_nxt = codes_r - 32'd1;
                  phase_nxt = next_phase(codes_r - 32'd1, ol_r);
                end else begin
                  phase_nxt = PH_CODE;
                end
              end
              PH_CODE, PH_PAYLOAD: begin
                state_nxt = S_RD;
              end
              PH_DONE: begin
                state_nxt = S_FIN;
              end
              default: begin
                state_nxt = S_FIN;
              end
            endcase
          end
        end
      end
      S_RD: begin
        if (k_r[3] || err_r ||
            ((phase_r == PH_CODE) ? (idx_r >= len_r) : (phase_r != PH_PAYLOAD))) begin
          state_nxt = S_FIN;
        end else begin
          ram_re    = 1'b1;
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        if (phase_r == PH_CODE) begin
          if (rd_child == '0) begin
            if (nfree_r >= (AW+1)'(NODE_COUNT)) begin
              err_nxt   = 1'b1;
              ecode_nxt = ST_TABLE_ERR;
              state_nxt = S_FIN;
            end else begin
              ram_we = 1'b1;
              ram_wa = cur_r;
              if (bit_v) begin
                ram_wd = {rd_leaf, nfree_r[AW-1:0], rd_c0, rd_data[7:0]};
              end else begin
                ram_wd = {rd_leaf, rd_c1, nfree_r[AW-1:0], rd_data[7:0]};
              end
              child_nxt = nfree_r[AW-1:0];
              state_nxt = S_ALLOC;
            end
          end else if (final_bit) begin
            err_nxt   = 1'b1;
            ecode_nxt = ST_TABLE_ERR;
            state_nxt = S_FIN;
          end else begin
            child_nxt = rd_child;
            ram_re    = 1'b1;
            ram_ra    = rd_child;
            state_nxt = S_CHK2;
          end
        end else begin
          if (rd_child == '0) begin
            err_nxt   = 1'b1;
            ecode_nxt = ST_NO_CHILD;
            state_nxt = S_FIN;
          end else begin
            child_nxt = rd_child;
            ram_re    = 1'b1;
            ram_ra    = rd_child;
            state_nxt = S_PCHK;
          end
        end
      end
      S_ALLOC: begin
        ram_we    = 1'b1;
        ram_wa    = child_r;
        ram_wd    = final_bit ? {1'b1, {(2*AW){1'b0}}, pend_r} : '0;
        nfree_nxt = nfree_r + (AW+1)'(1);
        idx_nxt   = idx_r + 8'd1;
        cur_nxt   = child_r;
        k_nxt     = k_r + 4'd1;
        if (final_bit) begin
          codes_nxt = codes_r - 32'd1;
          phase_nxt = next_phase(codes_r - 32'd1, ol_r);
          cur_nxt   = '0;
          k_nxt     = 4'd8;
        end
        state_nxt = S_RD;
      end
      S_CHK2: begin
        if (rd_leaf) begin
          err_nxt   = 1'b1;
          ecode_nxt = ST_TABLE_ERR;
          state_nxt = S_FIN;
        end else begin
          idx_nxt   = idx_r + 8'd1;
          cur_nxt   = child_r;
          k_nxt     = k_r + 4'd1;
          state_nxt = S_RD;
        end
      end
      S_PCHK: begin
        if (rd_leaf) begin
          if (!hold_v_r || out_free) begin
            if (hold_v_r) begin
              push                   = 1'b1;
              push_data.symbol       = hold_r;
              push_data.symbol_valid = 1'b1;
            end
            hold_nxt   = rd_data[7:0];
            hold_v_nxt = 1'b1;
            cur_nxt    = '0;
            ol_nxt     = ol_r - 32'd1;
            if (ol_r == 32'd1) begin
              phase_nxt = PH_DONE;
            end
            k_nxt     = k_r + 4'd1;
            state_nxt = S_RD;
          end
        end else begin
          cur_nxt   = child_r;
          k_nxt     = k_r + 4'd1;
          state_nxt = S_RD;
        end
      end
      S_FIN: begin
        if (out_free) begin
          push                   = 1'b1;
          push_data.symbol       = hold_v_r ? hold_r : 8'd0;
          push_data.symbol_valid = hold_v_r;
          push_data.last_symbol  = 1'b1;
          push_data.status       = status;
          if (trunc) begin
            err_nxt   = 1'b1;
            ecode_nxt = ST_TRUNCATED;
          end
          hold_v_nxt = 1'b0;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_COUNT;
      hdr_r       <= 2'd0;
      codes_r     <= 32'd0;
      ol_r        <= 32'd0;
      pend_r      <= 8'd0;
      len_r       <= 8'd0;
      idx_r       <= 8'd0;
      cur_r       <= '0;
      nfree_r     <= (AW+1)'(1);
      err_r       <= 1'b0;
      ecode_r     <= ST_RUNNING;
      end_r       <= 1'b0;
      k_r         <= 4'd0;
      hold_v_r    <= 1'b0;
      init_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      phase_r  <= phase_nxt;
      hdr_r    <= hdr_nxt;
      codes_r  <= codes_nxt;
      ol_r     <= ol_nxt;
      pend_r   <= pend_nxt;
      len_r    <= len_nxt;
      idx_r    <= idx_nxt;
      cur_r    <= cur_nxt;
      nfree_r  <= nfree_nxt;
      err_r    <= err_nxt;
      ecode_r  <= ecode_nxt;
      end_r    <= end_nxt;
      k_r      <= k_nxt;
      hold_v_r <= hold_v_nxt;
      init_r   <= init_nxt;
      if (push) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    b_r     <= b_nxt;
    child_r <= child_nxt;
    hold_r  <= hold_nxt;
    if (push) begin
      out_data_r <= push_data;
    end
  end

endmodule
`default_nettype wire
